@@ hw/rtl/lfc_pkg.sv @@
// ----------------------------------------------------------------------------
// lfc_pkg
// Types, register codes, reset values and the line position table for the
// PD line-follow controller.
// ----------------------------------------------------------------------------
package lfc_pkg;

  localparam int SensorCount = 5;
  localparam int DivBits     = 12;

  localparam logic [2:0] RegBlackLevel  = 3'd0;
  localparam logic [2:0] RegLeftBase    = 3'd1;
  localparam logic [2:0] RegRightBase   = 3'd2;
  localparam logic [2:0] RegSpeedLimit  = 3'd3;
  localparam logic [2:0] RegCorrLimit   = 3'd4;
  localparam logic [2:0] RegKpDivisor   = 3'd5;
  localparam logic [2:0] RegKdDivisor   = 3'd6;
  localparam logic [2:0] RegTurnNeg     = 3'd7;

  localparam logic [1:0] ModeFollow   = 2'd0;
  localparam logic [1:0] ModeLost     = 2'd1;
  localparam logic [1:0] ModeAllBlack = 2'd2;

  localparam logic        RstBlackLevel = 1'b0;
  localparam logic [9:0]  RstLeftBase   = 10'd110;
  localparam logic [9:0]  RstRightBase  = 10'd110;
  localparam logic [9:0]  RstSpeedLimit = 10'd180;
  localparam logic [9:0]  RstCorrLimit  = 10'd50;
  localparam logic [7:0]  RstKpDivisor  = 8'd20;
  localparam logic [7:0]  RstKdDivisor  = 8'd45;
  localparam logic        RstTurnNeg    = 1'b1;

  localparam logic [11:0] CenterPos = 12'd2000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // centroid of the line sensors, index weight 1000, truncated
  function automatic logic [11:0] line_pos(input logic [4:0] mask);
    logic [11:0] pos;
    case (mask)
      5'd0:  pos = 12'd2000;
      5'd1:  pos = 12'd0;
      5'd2:  pos = 12'd1000;
      5'd3:  pos = 12'd500;
      5'd4:  pos = 12'd2000;
      5'd5:  pos = 12'd1000;
      5'd6:  pos = 12'd1500;
      5'd7:  pos = 12'd1000;
      5'd8:  pos = 12'd3000;
      5'd9:  pos = 12'd1500;
      5'd10: pos = 12'd2000;
      5'd11: pos = 12'd1333;
      5'd12: pos = 12'd2500;
      5'd13: pos = 12'd1666;
      5'd14: pos = 12'd2000;
      5'd15: pos = 12'd1500;
      5'd16: pos = 12'd4000;
      5'd17: pos = 12'd2000;
      5'd18: pos = 12'd2500;
      5'd19: pos = 12'd1666;
      5'd20: pos = 12'd3000;
      5'd21: pos = 12'd2000;
      5'd22: pos = 12'd2333;
      5'd23: pos = 12'd1750;
      5'd24: pos = 12'd3500;
      5'd25: pos = 12'd2333;
      5'd26: pos = 12'd2666;
      5'd27: pos = 12'd2000;
      5'd28: pos = 12'd3000;
      5'd29: pos = 12'd2250;
      5'd30: pos = 12'd2500;
      default: pos = 12'd2000;
    endcase
    return pos;
  endfunction

endpackage

@@ hw/rtl/lfc_serial_div.sv @@
// ----------------------------------------------------------------------------
// lfc_serial_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfc_serial_div import lfc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DivBits-1:0] dividend,
  input  logic [7:0]         divisor,
  output logic [DivBits-1:0] quotient,
  output div_stat_t          stat
);

  logic [7:0]         rem;
  logic [DivBits-1:0] quo;
  logic [7:0]         dvs;
  logic [3:0]         cnt;
  logic               busy;
  logic               done;
  logic [8:0]         trial;
  logic [8:0]         trial_sub;
  logic               fits;

  assign trial     = {rem, quo[DivBits-1]};
  assign fits      = trial >= {1'b0, dvs};
  assign trial_sub = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'(DivBits);
      end else if (busy) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? trial_sub[7:0] : trial[7:0];
      quo <= {quo[DivBits-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

@@ hw/rtl/pd_line_follow_controller.sv @@
// ----------------------------------------------------------------------------
// pd_line_follow_controller
// PD steering from five reflectance sensors, with stop on lost or all-black.
//
// Channel   Dir  Handshake            Content
// s_*       in   s_tvalid/s_tready    sensor_bits
// m_*       out  m_tvalid/m_tready    speeds, stop, mode, position, error,
//                                     mask, count
// cfg_*     in   cfg_wen              register index and data
//
// A followed request runs two 12-step passes of the shared bit-serial
// divider (P, then D), each a start then a wait step, and a mix step; a
// stop request goes straight to emit. No request is taken until the last
// is emitted, but the result register lets the next one in while a result
// waits; a stalled output holds the block only at its last step. Reset is
// synchronous and restores config, state, output valid and stored error.
// ----------------------------------------------------------------------------
module pd_line_follow_controller import lfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] sensor_bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [9:0] left_cmd, [19:10] right_cmd,
                                 // [20] stop_motors, [22:21] track_mode,
                                 // [34:23] line_position, [46:35] line_error,
                                 // [51:47] line_mask, [54:52] line_count
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PSTART = 3'd1;
  localparam logic [2:0] S_PWAIT  = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DWAIT  = 3'd4;
  localparam logic [2:0] S_MIX    = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic        black_level;
  logic [9:0]  left_base;
  logic [9:0]  right_base;
  logic [9:0]  speed_limit;
  logic [9:0]  corr_limit;
  logic [7:0]  kp_div;
  logic [7:0]  kd_div;
  logic        turn_neg;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic signed [11:0] prev_error;
  logic [4:0]  mask;
  logic [2:0]  count;
  logic [11:0] position;
  logic signed [11:0] error;
  logic [1:0]  mode;
  logic signed [13:0] p_term;
  logic signed [13:0] d_term;
  logic signed [10:0] corr;

  logic [4:0]  in_mask;
  logic [2:0]  in_count;
  logic [11:0] in_pos;
  logic [1:0]  in_mode;
  logic        accept;
  logic        out_free;

  logic signed [12:0] diff;
  logic [11:0] err_mag;
  logic [11:0] diff_mag;
  logic        div_start;
  logic [DivBits-1:0] div_dividend;
  logic [7:0]  div_divisor;
  logic [DivBits-1:0] div_quot;
  div_stat_t   div_stat;
  logic signed [13:0] quot_ext;

  logic signed [13:0] pd_sum;
  logic signed [13:0] pd_signed;
  logic signed [13:0] lim_pos;
  logic signed [13:0] lim_neg;
  logic signed [11:0] left_raw;
  logic signed [11:0] right_raw;
  logic [9:0]  left_cmd;
  logic [9:0]  right_cmd;
  logic        stop;

  always_ff @(posedge clk) begin
    if (rst) begin
      black_level <= RstBlackLevel;
      left_base   <= RstLeftBase;
      right_base  <= RstRightBase;
      speed_limit <= RstSpeedLimit;
      corr_limit  <= RstCorrLimit;
      kp_div      <= RstKpDivisor;
      kd_div      <= RstKdDivisor;
      turn_neg    <= RstTurnNeg;
    end else if (cfg_wen) begin
      case (cfg_index)
        RegBlackLevel: black_level <= cfg_data[0];
        RegLeftBase:   left_base   <= cfg_data;
        RegRightBase:  right_base  <= cfg_data;
        RegSpeedLimit: speed_limit <= cfg_data;
        RegCorrLimit:  corr_limit  <= cfg_data;
        RegKpDivisor:  kp_div      <= cfg_data[7:0];
        RegKdDivisor:  kd_div      <= cfg_data[7:0];
        RegTurnNeg:    turn_neg    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_count = '0;
    for (int i = 0; i < SensorCount; i++) begin
      in_mask[i] = s_tdata[i] == black_level;
      in_count   = in_count + {2'b0, in_mask[i]};
    end
    in_pos = line_pos(in_mask);
    if (in_count == 3'd0) begin
      in_mode = ModeLost;
    end else if (in_count >= 3'd4) begin
      in_mode = ModeAllBlack;
    end else begin
      in_mode = ModeFollow;
    end
  end

  assign s_tready = state == S_IDLE;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign stop     = mode != ModeFollow;

  assign diff     = {error[11], error} - {prev_error[11], prev_error};
  assign err_mag  = error[11] ? 12'(-error) : error;
  assign diff_mag = diff[12] ? 12'(-diff) : diff[11:0];

  assign div_start    = state == S_PSTART || state == S_DSTART;
  assign div_dividend = state == S_PSTART ? err_mag : diff_mag;
  always_comb begin
    if (state == S_PSTART) begin
      div_divisor = kp_div == 8'd0 ? 8'd1 : kp_div;
    end else begin
      div_divisor = kd_div == 8'd0 ? 8'd1 : kd_div;
    end
  end

  lfc_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  assign quot_ext = {2'b0, div_quot};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = in_mode == ModeFollow ? S_PSTART : S_EMIT;
      S_PSTART: state_next = S_PWAIT;
      S_PWAIT:  if (div_stat.done) state_next = S_DSTART;
      S_DSTART: state_next = S_DWAIT;
      S_DWAIT:  if (div_stat.done) state_next = S_MIX;
      S_MIX:    state_next = S_EMIT;
      S_EMIT:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prev_error <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EMIT && out_free) begin
        m_tvalid   <= 1'b1;
        prev_error <= stop ? 12'sd0 : error;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign pd_sum    = p_term + d_term;
  assign pd_signed = turn_neg ? -pd_sum : pd_sum;
  assign lim_pos   = {4'b0, corr_limit};
  assign lim_neg   = -lim_pos;

  always_ff @(posedge clk) begin
    if (accept) begin
      mask     <= in_mask;
      count    <= in_count;
      position <= in_pos;
      error    <= in_pos - CenterPos;
      mode     <= in_mode;
    end
    if (state == S_PWAIT && div_stat.done) begin
      p_term <= error[11] ? -quot_ext : quot_ext;
    end
    if (state == S_DWAIT && div_stat.done) begin
      d_term <= diff[12] ? -quot_ext : quot_ext;
    end
    if (state == S_MIX) begin
      if (pd_signed > lim_pos) begin
        corr <= lim_pos[10:0];
      end else if (pd_signed < lim_neg) begin
        corr <= lim_neg[10:0];
      end else begin
        corr <= pd_signed[10:0];
      end
    end
  end

  assign left_raw  = {2'b0, left_base} + {corr[10], corr};
  assign right_raw = {2'b0, right_base} - {corr[10], corr};

  always_comb begin
    if (stop || left_raw[11]) begin
      left_cmd = '0;
    end else if (left_raw[10:0] > {1'b0, speed_limit}) begin
      left_cmd = speed_limit;
    end else begin
      left_cmd = left_raw[9:0];
    end
    if (stop || right_raw[11]) begin
      right_cmd = '0;
    end else if (right_raw[10:0] > {1'b0, speed_limit}) begin
      right_cmd = speed_limit;
    end else begin
      right_cmd = right_raw[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      m_tdata <= {1'b0, count, mask, error, position, mode, stop,
                  right_cmd, left_cmd};
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted twice without a result");

  a_stop_speeds_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[20] |-> m_tdata[19:0] == 20'd0)
    else $error("stop result carries nonzero speed");

  a_stop_matches_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[20] == (m_tdata[22:21] != ModeFollow))
    else $error("stop flag disagrees with mode");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_PWAIT || state == S_DWAIT)
    else $error("divider finished outside a wait step");

endmodule
